[hw/rtl/mbe_pkg.sv]
// Package for the multibrot escape iterator: constants, tables and helpers.
package mbe_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int MAX_COLS = 2048;
  localparam int MAX_ROWS = 2048;
  localparam int P_MIN = 2;
  localparam int P_MAX = 8;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_X_MIN    = 3'd0;
  localparam logic [2:0] REG_Y_MAX    = 3'd1;
  localparam logic [2:0] REG_STEP_X   = 3'd2;
  localparam logic [2:0] REG_STEP_Y   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER = 3'd4;
  localparam logic [2:0] REG_EXPONENT = 3'd5;

  // Binomial coefficients C(p,k), p and k up to 8
  localparam logic [6:0] BINOM [9][9] = '{
    '{7'd1, 7'd0, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd1, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd2, 7'd1,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd3, 7'd3,  7'd1,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd4, 7'd6,  7'd4,  7'd1,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd5, 7'd10, 7'd10, 7'd5,  7'd1,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd6, 7'd15, 7'd20, 7'd15, 7'd6,  7'd1,  7'd0, 7'd0},
    '{7'd1, 7'd7, 7'd21, 7'd35, 7'd35, 7'd21, 7'd7,  7'd1, 7'd0},
    '{7'd1, 7'd8, 7'd28, 7'd56, 7'd70, 7'd56, 7'd28, 7'd8, 7'd1}
  };

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7fff_ffff;
    lo = -64'sh0000_0000_8000_0000;
    if (a > hi) return 32'sh7fff_ffff;
    else if (a < lo) return 32'sh8000_0000;
    else return a[31:0];
  endfunction

endpackage

[hw/rtl/mbe_fmul.sv]
// Shared signed 32x32 multiplier with registered product and fixed-point scaling.
module mbe_fmul
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod,
  output logic signed [63:0] shifted,
  output logic signed [31:0] fm
);

  // Product register
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Floor shift by the fraction width, then saturate
  assign shifted = prod >>> FRAC_BITS;
  assign fm      = sat32(shifted);

endmodule

[hw/rtl/multibrot_escape_iterator_core.sv]
// Top level: multibrot escape-time iterator around one shared multiplier.
// One pixel at a time; the rate is set by the single multiplier.
// Input is taken again as soon as the result sits in the output register.
// Reset (rst, synchronous) restores register defaults and empties the output register.
module multibrot_escape_iterator_core
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // col [10:0], row [21:11], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // iterations [15:0]
  output logic [0:0]  m_tuser,   // escaped [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int MAG_W = (FRAC_BITS + 4 > 66 - FRAC_BITS) ? FRAC_BITS + 4 : 66 - FRAC_BITS;
  localparam logic signed [31:0] ONE =
    (FRAC_BITS <= 30) ? (32'sd1 <<< FRAC_BITS) : 32'sh7fff_ffff;
  localparam logic signed [MAG_W-1:0] FOUR = MAG_W'(4) << FRAC_BITS;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CX_I = 5'd1;
  localparam logic [4:0] S_CX_W = 5'd2;
  localparam logic [4:0] S_CY_I = 5'd3;
  localparam logic [4:0] S_CY_W = 5'd4;
  localparam logic [4:0] S_CHK  = 5'd5;
  localparam logic [4:0] S_PU_I = 5'd6;
  localparam logic [4:0] S_PU_W = 5'd7;
  localparam logic [4:0] S_PV_I = 5'd8;
  localparam logic [4:0] S_PV_W = 5'd9;
  localparam logic [4:0] S_TM_I = 5'd10;
  localparam logic [4:0] S_TM_W = 5'd11;
  localparam logic [4:0] S_UPD  = 5'd12;
  localparam logic [4:0] S_MR_I = 5'd13;
  localparam logic [4:0] S_MR_W = 5'd14;
  localparam logic [4:0] S_MI_I = 5'd15;
  localparam logic [4:0] S_MI_W = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  // Configuration registers
  logic signed [31:0] x_min, y_max;
  logic [30:0] step_x, step_y;
  logic [15:0] max_iter;
  logic [3:0]  exponent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min    <= -32'sd536870912;
      y_max    <= 32'sd268435456;
      step_x   <= 31'd393216;
      step_y   <= 31'd393216;
      max_iter <= 16'd255;
      exponent <= 4'd6;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_MIN:    x_min    <= cfg_data;
        REG_Y_MAX:    y_max    <= cfg_data;
        REG_STEP_X:   step_x   <= cfg_data[30:0];
        REG_STEP_Y:   step_y   <= cfg_data[30:0];
        REG_MAX_ITER: max_iter <= cfg_data[15:0];
        REG_EXPONENT: exponent <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Working state
  logic [4:0]  state;
  logic [10:0] col, row;
  logic [3:0]  p_r, n, k;
  logic [15:0] mi, cnt;
  logic signed [31:0] cx, cy, zr, zi;
  logic signed [41:0] re, im;
  logic signed [MAG_W-1:0] magr, mag;
  logic signed [31:0] up [9];
  logic signed [31:0] vp [9];

  logic signed [31:0] op_a, op_b, fm;
  logic signed [63:0] prod, shifted;
  logic [3:0] ua, va;
  logic signed [31:0] u_rd, v_rd;
  logic signed [39:0] term;

  mbe_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
    .clk(clk), .a(op_a), .b(op_b), .prod(prod), .shifted(shifted), .fm(fm)
  );

  // Power table read addresses
  always_comb begin
    ua = 4'd0;
    va = 4'd0;
    if (state == S_TM_I) begin
      ua = p_r - k;
      va = k;
    end else begin
      ua = n - 4'd1;
      va = n - 4'd1;
    end
  end
  assign u_rd = up[ua];
  assign v_rd = vp[va];

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_CX_I: begin op_a = {21'd0, col}; op_b = {1'b0, step_x}; end
      S_CY_I: begin op_a = {21'd0, row}; op_b = {1'b0, step_y}; end
      S_PU_I: begin op_a = u_rd; op_b = zr; end
      S_PV_I: begin op_a = v_rd; op_b = zi; end
      S_TM_I: begin op_a = u_rd; op_b = v_rd; end
      S_MR_I: begin op_a = zr; op_b = zr; end
      S_MI_I: begin op_a = zi; op_b = zi; end
      default: ;
    endcase
  end

  assign term = $signed({1'b0, BINOM[p_r][k]}) * fm;
  assign s_tready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // result leaves on its transfer unless a new one is loaded in the same cycle
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          col   <= 11'(s_tdata[10:0] % MAX_COLS);
          row   <= 11'(s_tdata[21:11] % MAX_ROWS);
          p_r   <= (exponent < 4'(P_MIN)) ? 4'(P_MIN) :
                   (exponent > 4'(P_MAX)) ? 4'(P_MAX) : exponent;
          mi    <= max_iter;
          cnt   <= '0;
          mag   <= '0;
          zr    <= '0;
          zi    <= '0;
          up[0] <= ONE;
          vp[0] <= ONE;
          state <= S_CX_I;
        end
        S_CX_I: state <= S_CX_W;
        S_CX_W: begin
          cx    <= sat32(64'(x_min) + prod);
          state <= S_CY_I;
        end
        S_CY_I: state <= S_CY_W;
        S_CY_W: begin
          cy    <= sat32(64'(y_max) - prod);
          state <= S_CHK;
        end
        S_CHK: begin
          if (cnt < mi && mag < FOUR) begin
            n     <= 4'd1;
            k     <= 4'd0;
            re    <= '0;
            im    <= '0;
            state <= S_PU_I;
          end else begin
            state <= S_DONE;
          end
        end
        S_PU_I: state <= S_PU_W;
        S_PU_W: begin
          up[n] <= fm;
          state <= S_PV_I;
        end
        S_PV_I: state <= S_PV_W;
        S_PV_W: begin
          vp[n] <= fm;
          if (n == p_r) state <= S_TM_I;
          else begin
            n     <= n + 4'd1;
            state <= S_PU_I;
          end
        end
        S_TM_I: state <= S_TM_W;
        S_TM_W: begin
          // i^k: even k to the real part, odd to the imaginary; k[1] flips sign
          if (!k[0]) re <= k[1] ? re - 42'(term) : re + 42'(term);
          else       im <= k[1] ? im - 42'(term) : im + 42'(term);
          if (k == p_r) state <= S_UPD;
          else begin
            k     <= k + 4'd1;
            state <= S_TM_I;
          end
        end
        S_UPD: begin
          zr    <= sat32(64'(re + 42'(cx)));
          zi    <= sat32(64'(im + 42'(cy)));
          state <= S_MR_I;
        end
        S_MR_I: state <= S_MR_W;
        S_MR_W: begin
          magr  <= shifted[MAG_W-1:0];
          state <= S_MI_I;
        end
        S_MI_I: state <= S_MI_W;
        S_MI_W: begin
          mag   <= magr + shifted[MAG_W-1:0];
          cnt   <= cnt + 16'd1;
          state <= S_CHK;
        end
        S_DONE: if (!m_tvalid || m_tready) begin
          m_tvalid   <= 1'b1;
          m_tdata    <= cnt;
          m_tuser[0] <= (mag >= FOUR);
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (cnt <= mi))
    else $error("iteration count passed its limit");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while busy");

  a_pow_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_PU_I) |-> (n != 4'd0 && n <= p_r))
    else $error("power index out of range");

  a_term_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_TM_I) |-> (k <= p_r))
    else $error("term index out of range");

endmodule
